[hdl/hcos_pkg.sv]
// ----------------------------------------------------------------------------
// hcos_pkg: shared types and constants
// Transaction payloads, opcodes and register map of the clock offset engine.
// ----------------------------------------------------------------------------
`default_nettype none
package hcos_pkg;
    localparam int unsigned ID_BITS = 16;
    localparam int unsigned ADDR_BITS = 5;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam logic [63:0] INT63_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_DUE     = 3'd1,
        OP_SENT    = 3'd2,
        OP_REPLY   = 3'd3,
        OP_FINISH  = 3'd4,
        OP_CONVERT = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        REG_MODE     = 3'd0,
        REG_RESYNC   = 3'd1,
        REG_TIMEOUT  = 3'd2,
        REG_MAXDELAY = 3'd3,
        REG_BURST    = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        FIN_RUNNING = 2'd0,
        FIN_COMMIT  = 2'd1,
        FIN_FAILED  = 2'd2
    } fin_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [63:0] now;
        logic [15:0] request_id;
        logic [63:0] host_receive_time;
        logic [63:0] host_send_time;
        logic [63:0] local_time;
    } in_item_t;

    typedef struct packed {
        logic        flag;
        logic [1:0]  finish_status;
        logic [62:0] converted_time;
        logic [1:0]  quality;
    } out_item_t;

    typedef struct packed {
        logic        wall_clock_mode;
        logic [31:0] resync_interval;
        logic [31:0] reply_timeout;
        logic [31:0] max_path_delay;
        logic [3:0]  burst_length;
    } cfg_t;

    // front-end classification of a reply, independent of engine state
    typedef struct packed {
        logic        host_ok;     // host stamps ordered and in range, now in range
        logic [63:0] proc;        // host processing time
        logic [63:0] half_proc_h; // h2 + proc/2
        logic [63:0] limit;       // freshness window
    } pre_t;

    typedef struct packed {
        in_item_t item;
        pre_t     pre;
    } work_t;
endpackage
`default_nettype wire

[hdl/hcos_front.sv]
// ----------------------------------------------------------------------------
// hcos_front: input stage
// Registers accepted transactions and precomputes state-free reply checks.
// ----------------------------------------------------------------------------
`default_nettype none
module hcos_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire hcos_pkg::in_item_t s_data,
    input  wire hcos_pkg::cfg_t   cfg,
    output logic                  q_valid,
    input  wire logic             q_ready,
    output hcos_pkg::work_t       q_data
);
    import hcos_pkg::*;

    logic  valid_reg;
    work_t data_reg;
    pre_t  pre;
    logic [63:0] h2, h3;
    logic [35:0] prod;

    assign h2 = s_data.host_receive_time;
    assign h3 = s_data.host_send_time;
    assign prod = 36'(cfg.burst_length) * 36'(cfg.reply_timeout);

    always_comb begin
        pre.proc = h3 - h2;
        pre.host_ok = (h3 >= h2) && (h2 <= INT63_MAX) && (h3 <= INT63_MAX)
                      && (s_data.now <= INT63_MAX);
        pre.half_proc_h = h2 + (pre.proc >> 1);
        pre.limit = 64'(cfg.resync_interval) + 64'(prod);
    end

    assign s_ready = !valid_reg || q_ready;
    assign q_valid = valid_reg;
    assign q_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            data_reg.item <= s_data;
            data_reg.pre  <= pre;
        end
    end
endmodule
`default_nettype wire

[hdl/hcos_queue.sv]
// ----------------------------------------------------------------------------
// hcos_queue: decoupling fifo
// Small register fifo between the front end and the engine.
// ----------------------------------------------------------------------------
`default_nettype none
module hcos_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            w_valid,
    output logic                 w_ready,
    input  wire hcos_pkg::work_t w_data,
    output logic                 r_valid,
    input  wire logic            r_ready,
    output hcos_pkg::work_t      r_data
);
    import hcos_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    work_t mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wp_reg, rp_reg;
    logic [PW:0]   cnt_reg;
    logic wr, rd;

    assign w_ready = cnt_reg != (PW+1)'(QUEUE_DEPTH);
    assign r_valid = cnt_reg != '0;
    assign r_data  = mem_reg[rp_reg];
    assign wr = w_valid && w_ready;
    assign rd = r_valid && r_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= wp_reg + 1'b1;
            if (rd) rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(wr) - (PW+1)'(rd);
        end
        if (wr) mem_reg[wp_reg] <= w_data;
    end
endmodule
`default_nettype wire

[hdl/hcos_engine.sv]
// ----------------------------------------------------------------------------
// hcos_engine: synchronization state machine
// Executes one transaction per cycle against the sync state while m_ready does not stall the result, registered result.
// ----------------------------------------------------------------------------
`default_nettype none
module hcos_engine (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire hcos_pkg::cfg_t    cfg,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  wire hcos_pkg::work_t   q_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output hcos_pkg::out_item_t    m_data
);
    import hcos_pkg::*;

    logic started_reg, started_next, mode_wall_reg, mode_wall_next;
    logic ready_reg, ready_next, pending_reg, pending_next;
    logic [ID_BITS-1:0] tag_reg, tag_next;
    logic [63:0] stamp_reg, stamp_next;
    logic in_burst_reg, in_burst_next;
    logic [3:0] att_reg, att_next;
    logic have_reg, have_next;
    logic [31:0] bdelay_reg, bdelay_next;
    logic [63:0] boff_reg, boff_next, coff_reg, coff_next;
    logic [63:0] lct_reg, lct_next, nbt_reg, nbt_next;
    logic out_valid_reg;
    out_item_t out_reg, res;

    logic go;
    in_item_t it;
    pre_t pre;
    logic [63:0] age, rtt, dly, off, loc, sum;
    logic timed_out;

    assign it  = q_data.item;
    assign pre = q_data.pre;
    assign q_ready = !out_valid_reg || m_ready;
    assign go = q_valid && q_ready;
    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

    always_comb begin
        started_next = started_reg; mode_wall_next = mode_wall_reg;
        ready_next = ready_reg; pending_next = pending_reg; tag_next = tag_reg;
        stamp_next = stamp_reg; in_burst_next = in_burst_reg; att_next = att_reg;
        have_next = have_reg; bdelay_next = bdelay_reg; boff_next = boff_reg;
        coff_next = coff_reg; lct_next = lct_reg; nbt_next = nbt_reg;
        res = '0;
        res.flag = 1'b1;
        age = it.now - stamp_reg;
        timed_out = age >= 64'(cfg.reply_timeout);
        rtt = age;
        dly = rtt - pre.proc;
        sum = '0;
        loc = it.local_time;
        off = mode_wall_reg ? coff_reg : '0;
        case (it.op)
            OP_START: begin
                started_next = 1'b1; mode_wall_next = cfg.wall_clock_mode;
                ready_next = !cfg.wall_clock_mode; pending_next = 1'b0;
                tag_next = '0; stamp_next = '0; in_burst_next = 1'b0;
                att_next = '0; have_next = 1'b0; bdelay_next = '0;
                boff_next = '0; coff_next = '0; lct_next = '0;
                nbt_next = it.now;
            end
            OP_DUE: begin
                res.flag = 1'b0;
                if (started_reg && mode_wall_reg) begin
                    if (pending_reg && timed_out) pending_next = 1'b0;
                    if (!pending_next) begin
                        if (in_burst_reg) begin
                            res.flag = att_reg < cfg.burst_length;
                        end else if (it.now >= nbt_reg) begin
                            in_burst_next = 1'b1; att_next = '0; have_next = 1'b0;
                            res.flag = cfg.burst_length != 4'd0;
                        end
                    end
                end
            end
            OP_SENT: begin
                pending_next = 1'b1;
                tag_next = it.request_id[ID_BITS-1:0];
                stamp_next = it.now;
                if (att_reg != 4'hF) att_next = att_reg + 4'd1;
            end
            OP_REPLY: begin
                res.flag = 1'b0;
                if (pending_reg && it.request_id[ID_BITS-1:0] == tag_reg) begin
                    pending_next = 1'b0;
                    if (it.now >= stamp_reg && !timed_out && pre.host_ok
                        && pre.proc <= rtt && dly <= 64'(cfg.max_path_delay)) begin
                        res.flag = 1'b1;
                        if (!have_reg || dly[31:0] < bdelay_reg) begin
                            have_next = 1'b1;
                            bdelay_next = dly[31:0];
                            boff_next = pre.half_proc_h - (stamp_reg + (rtt >> 1));
                        end
                    end
                end
            end
            OP_FINISH: begin
                if (in_burst_reg && !pending_reg && att_reg >= cfg.burst_length) begin
                    in_burst_next = 1'b0;
                    nbt_next = it.now + 64'(cfg.resync_interval);
                    if (have_reg) begin
                        coff_next = boff_reg; lct_next = it.now; ready_next = 1'b1;
                        res.finish_status = FIN_COMMIT;
                    end else begin
                        res.finish_status = FIN_FAILED;
                    end
                end
            end
            OP_CONVERT: begin
                sum = loc + off;
                res.flag = ready_reg && loc <= INT63_MAX && !sum[63]
                           && !(off[63] && loc < (64'd0 - off));
                if (res.flag) res.converted_time = sum[62:0];
            end
            default: ;
        endcase
        // freshness after the step
        if (!ready_next) res.quality = 2'd0;
        else if (!mode_wall_next) res.quality = 2'd1;
        else res.quality = (it.now - lct_next > pre.limit) ? 2'd2 : 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg <= 1'b0; mode_wall_reg <= 1'b0; ready_reg <= 1'b0;
            pending_reg <= 1'b0; tag_reg <= '0; stamp_reg <= '0;
            in_burst_reg <= 1'b0; att_reg <= '0; have_reg <= 1'b0;
            bdelay_reg <= '0; boff_reg <= '0; coff_reg <= '0;
            lct_reg <= '0; nbt_reg <= '0; out_valid_reg <= 1'b0;
        end else begin
            if (q_ready) out_valid_reg <= q_valid;
            if (go) begin
                started_reg <= started_next; mode_wall_reg <= mode_wall_next;
                ready_reg <= ready_next; pending_reg <= pending_next;
                tag_reg <= tag_next; stamp_reg <= stamp_next;
                in_burst_reg <= in_burst_next; att_reg <= att_next;
                have_reg <= have_next; bdelay_reg <= bdelay_next;
                boff_reg <= boff_next; coff_reg <= coff_next;
                lct_reg <= lct_next; nbt_reg <= nbt_next;
            end
        end
        if (go) out_reg <= res;
    end

    a_no_ready_without_start: assert property (@(posedge aclk) disable iff (!aresetn)
        ready_reg |-> started_reg) else $error("ready without start");
    a_commit_sets_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        go && res.finish_status == FIN_COMMIT |=> ready_reg)
        else $error("commit did not set ready");
    a_output_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
endmodule
`default_nettype wire

[hdl/host_clock_offset_sync_engine.sv]
// ----------------------------------------------------------------------------
// host_clock_offset_sync_engine: min-delay host clock offset estimation
// path: input transaction passes front reg, fifo and result reg in turn
// throughput: one transaction per cycle while m_ready does not hold the result register
// reset: aresetn synchronous active low; state cleared, registers to defaults
// ----------------------------------------------------------------------------
`default_nettype none
module host_clock_offset_sync_engine (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire hcos_pkg::in_item_t   s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output hcos_pkg::out_item_t       m_data,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [hcos_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import hcos_pkg::*;

    cfg_t  cfg_reg;
    logic  fq_valid, fq_ready, qe_valid, qe_ready;
    work_t fq_data, qe_data;
    reg_idx_t idx;

    // register index from word address
    assign idx = reg_idx_t'(paddr[ADDR_BITS-1:2]);
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wall_clock_mode <= 1'b1;
            cfg_reg.resync_interval <= 32'd1000000;
            cfg_reg.reply_timeout   <= 32'd100000;
            cfg_reg.max_path_delay  <= 32'd50000;
            cfg_reg.burst_length    <= 4'd4;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                REG_MODE:     cfg_reg.wall_clock_mode <= pwdata[0];
                REG_RESYNC:   cfg_reg.resync_interval <= pwdata;
                REG_TIMEOUT:  cfg_reg.reply_timeout   <= pwdata;
                REG_MAXDELAY: cfg_reg.max_path_delay  <= pwdata;
                REG_BURST:    cfg_reg.burst_length    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_MODE:     prdata = {31'd0, cfg_reg.wall_clock_mode};
            REG_RESYNC:   prdata = cfg_reg.resync_interval;
            REG_TIMEOUT:  prdata = cfg_reg.reply_timeout;
            REG_MAXDELAY: prdata = cfg_reg.max_path_delay;
            REG_BURST:    prdata = {28'd0, cfg_reg.burst_length};
            default:      prdata = '0;
        endcase
    end

    // front end: accept and precheck each transaction
    hcos_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .cfg(cfg_reg),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    // decoupling queue
    hcos_queue u_queue (
        .aclk, .aresetn,
        .w_valid(fq_valid), .w_ready(fq_ready), .w_data(fq_data),
        .r_valid(qe_valid), .r_ready(qe_ready), .r_data(qe_data)
    );

    // back end: state update and result register
    hcos_engine u_engine (
        .aclk, .aresetn, .cfg(cfg_reg),
        .q_valid(qe_valid), .q_ready(qe_ready), .q_data(qe_data),
        .m_valid, .m_ready, .m_data
    );
endmodule
`default_nettype wire

[sim/host_clock_offset_sync_engine_tb.sv]
// ----------------------------------------------------------------------------
// host_clock_offset_sync_engine_tb: self-checking bench for the offset engine
// Drives operation transactions and register writes, predicts every result
// with a behavioral copy of the engine and checks results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

class offset_scoreboard;
    // configuration copy
    logic        cfg_wall;
    logic [31:0] cfg_resync;
    logic [31:0] cfg_timeout;
    logic [31:0] cfg_maxdelay;
    logic [3:0]  cfg_burst;
    // engine state copy
    bit          started, mode_wall, is_ready, pending, in_burst, have_sample;
    logic [15:0] pending_tag;
    logic [63:0] send_stamp, best_offset, committed_offset;
    logic [63:0] last_commit_time, next_burst_time, best_delay;
    logic [3:0]  attempt_count;
    hcos_pkg::out_item_t expected_results[$];
    int errors;

    function new();
        cfg_wall = 1'b1;
        cfg_resync = 32'd1000000;
        cfg_timeout = 32'd100000;
        cfg_maxdelay = 32'd50000;
        cfg_burst = 4'd4;
        errors = 0;
        clear_engine();
    endfunction

    function void clear_engine();
        started = 0; mode_wall = 0; is_ready = 0; pending = 0; in_burst = 0;
        have_sample = 0; pending_tag = '0; send_stamp = '0; best_offset = '0;
        committed_offset = '0; last_commit_time = '0; next_burst_time = '0;
        best_delay = '0; attempt_count = '0;
    endfunction

    function void write_reg(hcos_pkg::reg_idx_t idx, logic [31:0] value);
        case (idx)
            hcos_pkg::REG_MODE:     cfg_wall = value[0];
            hcos_pkg::REG_RESYNC:   cfg_resync = value;
            hcos_pkg::REG_TIMEOUT:  cfg_timeout = value;
            hcos_pkg::REG_MAXDELAY: cfg_maxdelay = value;
            hcos_pkg::REG_BURST:    cfg_burst = value[3:0];
            default: ;
        endcase
    endfunction

    function logic [1:0] quality(logic [63:0] now);
        logic [63:0] window;
        if (!is_ready) return 2'd0;
        if (!mode_wall) return 2'd1;
        window = 64'(cfg_resync) + 64'(cfg_burst) * 64'(cfg_timeout);
        return (now - last_commit_time > window) ? 2'd2 : 2'd1;
    endfunction

    function bit due_check(logic [63:0] now);
        if (!started || !mode_wall) return 0;
        if (pending && now - send_stamp >= 64'(cfg_timeout)) pending = 0;
        if (pending) return 0;
        if (!in_burst) begin
            if (now < next_burst_time) return 0;
            in_burst = 1;
            attempt_count = '0;
            have_sample = 0;
        end
        return attempt_count < cfg_burst;
    endfunction

    function bit take_reply(hcos_pkg::in_item_t it);
        logic [63:0] rtt, proc, delay, h2, h3, now;
        h2 = it.host_receive_time;
        h3 = it.host_send_time;
        now = it.now;
        if (!pending || it.request_id != pending_tag) return 0;
        pending = 0;
        if (now < send_stamp || now - send_stamp >= 64'(cfg_timeout) || h3 < h2
            || h2[63] || h3[63] || now[63]) return 0;
        rtt = now - send_stamp;
        proc = h3 - h2;
        if (proc > rtt) return 0;
        delay = rtt - proc;
        if (delay > 64'(cfg_maxdelay)) return 0;
        if (!have_sample || delay < best_delay) begin
            have_sample = 1;
            best_delay = delay;
            best_offset = (h2 + proc / 2) - (send_stamp + rtt / 2);
        end
        return 1;
    endfunction

    function logic [1:0] finish_burst(logic [63:0] now);
        if (!in_burst || pending || attempt_count < cfg_burst) return hcos_pkg::FIN_RUNNING;
        in_burst = 0;
        next_burst_time = now + 64'(cfg_resync);
        if (!have_sample) return hcos_pkg::FIN_FAILED;
        committed_offset = best_offset;
        last_commit_time = now;
        is_ready = 1;
        return hcos_pkg::FIN_COMMIT;
    endfunction

    function bit map_time(logic [63:0] lt, output logic [62:0] mapped);
        logic [63:0] off;
        mapped = '0;
        if (!is_ready || lt[63]) return 0;
        off = mode_wall ? committed_offset : 64'd0;
        if (off[63]) begin
            if (lt < -off) return 0;
        end else if (off != 0) begin
            if (lt > hcos_pkg::INT63_MAX - off) return 0;
        end
        mapped = 63'(lt + off);
        return 1;
    endfunction

    // an input transaction was accepted: predict its result
    function void note_input(hcos_pkg::in_item_t it);
        hcos_pkg::out_item_t r;
        logic [62:0] mapped;
        r = '0;
        r.flag = 1'b1;
        case (it.op)
            hcos_pkg::OP_START: begin
                clear_engine();
                started = 1;
                mode_wall = cfg_wall;
                is_ready = !cfg_wall;
                next_burst_time = it.now;
            end
            hcos_pkg::OP_DUE: r.flag = due_check(it.now);
            hcos_pkg::OP_SENT: begin
                pending = 1;
                pending_tag = it.request_id;
                send_stamp = it.now;
                if (attempt_count != 4'd15) attempt_count++;
            end
            hcos_pkg::OP_REPLY: r.flag = take_reply(it);
            hcos_pkg::OP_FINISH: r.finish_status = finish_burst(it.now);
            hcos_pkg::OP_CONVERT: begin
                r.flag = map_time(it.local_time, mapped);
                r.converted_time = mapped;
            end
            default: ;
        endcase
        r.quality = quality(it.now);
        expected_results.push_back(r);
    endfunction

    function void check_result(hcos_pkg::out_item_t got);
        hcos_pkg::out_item_t want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = expected_results.pop_front();
        if (got.flag !== want.flag)
            $display("%0t: flag expected %b actual %b", $time, want.flag, got.flag);
        if (got.finish_status !== want.finish_status)
            $display("%0t: finish_status expected %0d actual %0d", $time,
                     want.finish_status, got.finish_status);
        if (got.converted_time !== want.converted_time)
            $display("%0t: converted_time expected %h actual %h", $time,
                     want.converted_time, got.converted_time);
        if (got.quality !== want.quality)
            $display("%0t: quality expected %0d actual %0d", $time,
                     want.quality, got.quality);
        if (got !== want) errors++;
    endfunction
endclass

module host_clock_offset_sync_engine_tb;
    import hcos_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_item_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_item_t m_data;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    offset_scoreboard board = new();

    // idle control shared by both sides
    bit quiet_stretch = 0;   // no idling at all while set
    bit hold_receiver = 0;   // long back-pressure window
    int idle_cycles = 0;     // cycles since last accepted transaction or result

    // shadow of the stimulus view, used to build mostly well-formed bursts
    logic [63:0] board_time = 64'd1000;
    logic [15:0] last_tag = '0;

    always #10 aclk = ~aclk;

    host_clock_offset_sync_engine dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // result side: sample at rising edge, choose ready at falling edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(negedge aclk) begin
        if (hold_receiver) m_ready <= 1'b0;
        else if (quiet_stretch) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(99) >= 19);
    end

    // watchdog on lack of progress
    always @(posedge aclk) begin
        if (idle_cycles > STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // register write: setup then access phase
    task automatic write_register(reg_idx_t idx, logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_BITS'(4 * idx); pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        board.write_reg(idx, value);
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // offer one transaction, with a random gap before it unless quiet_stretch or hold_receiver
    // is set; valid stays high after acceptance until the next gap or the next transaction
    task automatic send_item(in_item_t it);
        if (!quiet_stretch && !hold_receiver) begin
            while ($urandom_range(99) < 19) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_input(it);
        @(negedge aclk);
    endtask

    // stop offering, wait until every expected result is back
    task automatic drain();
        s_valid <= 1'b0;
        while (board.expected_results.size() != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic in_item_t make_op(op_t op, logic [63:0] now);
        in_item_t it;
        it.op = op;
        it.now = now;
        it.request_id = $urandom();
        it.host_receive_time = rand64();
        it.host_send_time = rand64();
        it.local_time = rand64();
        return it;
    endfunction

    // a mostly well-formed burst: due, sent, reply (at times bad stamps or tag), maybe convert; then finish
    task automatic run_burst(logic [63:0] host_base);
        in_item_t it;
        int n;
        logic [63:0] h2, rtt, proc;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            board_time += $urandom_range(1, 50);
            send_item(make_op(OP_DUE, board_time));
            it = make_op(OP_SENT, board_time);
            last_tag = $urandom();
            it.request_id = last_tag;
            send_item(it);
            rtt = $urandom_range(0, 60000);
            board_time += rtt;
            proc = $urandom_range(0, 3) == 0 ? rtt + 1 : $urandom_range(0, int'(rtt));
            h2 = host_base + board_time + $urandom_range(0, 1000);
            it = make_op(OP_REPLY, board_time);
            it.request_id = ($urandom_range(9) == 0) ? 16'($urandom()) : last_tag;
            it.host_receive_time = h2;
            it.host_send_time = h2 + proc;
            send_item(it);
            if ($urandom_range(3) == 0) begin
                it = make_op(OP_CONVERT, board_time);
                it.local_time = $urandom_range(3) == 0 ? rand64() : board_time;
                send_item(it);
            end
        end
        board_time += $urandom_range(0, 2000);
        send_item(make_op(OP_FINISH, board_time));
    endtask

    task automatic random_phase(int count);
        in_item_t it;
        logic [63:0] host_base;
        host_base = {1'b0, 63'($urandom_range(0, 1) ? rand64() : 64'd0)};
        board_time = 64'($urandom_range(0, 100000));
        send_item(make_op(OP_START, board_time));
        for (int i = 0; i < count; ) begin
            if ($urandom_range(9) < 7) begin
                run_burst(host_base);
                i += 12;
            end else begin
                // noise: any opcode including unused ones, any field value
                it = make_op(op_t'($urandom_range(0, 7)),
                             $urandom_range(1) ? rand64() : board_time);
                if ($urandom_range(1)) it.request_id = last_tag;
                send_item(it);
                i++;
            end
        end
    endtask

    initial begin
        in_item_t it;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: wall mode basics and field extremes
        quiet_stretch = 1;
        it = make_op(OP_CONVERT, 64'd0);
        it.local_time = 64'd5;
        send_item(it);                               // not ready yet
        send_item(make_op(OP_DUE, 64'd0));           // due before start
        send_item(make_op(OP_START, 64'd100));
        send_item(make_op(OP_DUE, 64'd100));
        it = make_op(OP_SENT, 64'd100); it.request_id = 16'hFFFF; send_item(it);
        it = make_op(OP_REPLY, 64'd200); it.request_id = 16'h1234; send_item(it);
        it = make_op(OP_REPLY, 64'd300); it.request_id = 16'hFFFF;
        it.host_receive_time = 64'd5000; it.host_send_time = 64'd5050; send_item(it);
        send_item(make_op(OP_FINISH, 64'd310));      // burst not complete
        it = make_op(OP_SENT, 64'd400); it.request_id = 16'h0; send_item(it);
        it = make_op(OP_REPLY, 64'hFFFF_FFFF_FFFF_FFFF); it.request_id = 16'h0;
        send_item(it);                               // now out of signed range
        it = make_op(OP_SENT, 64'd500); send_item(it);
        send_item(make_op(OP_DUE, 64'd200000));      // expires pending request
        it = make_op(OP_SENT, 64'd600); send_item(it);
        it = make_op(OP_SENT, 64'd700); it.request_id = 16'h7; send_item(it);
        it = make_op(OP_REPLY, 64'd720); it.request_id = 16'h7;
        it.host_receive_time = 64'd9000; it.host_send_time = 64'd8000; send_item(it);
        send_item(make_op(OP_FINISH, 64'd800));      // commit with sample
        it = make_op(OP_CONVERT, 64'd900); it.local_time = 64'h7FFF_FFFF_FFFF_FFFF;
        send_item(it);                               // overflow past 2^63-1
        it = make_op(OP_CONVERT, 64'd900); it.local_time = 64'd0; send_item(it);
        it = make_op(OP_CONVERT, 64'hFFFF_FFFF_FFFF_FFFF);
        it.local_time = 64'h8000_0000_0000_0000; send_item(it);  // stale, bad input
        it = make_op(op_t'(3'd6), 64'd1000); send_item(it);
        it = make_op(op_t'(3'd7), 64'd1000); send_item(it);
        drain();

        // uptime mode and extreme registers
        write_register(REG_MODE, 32'd0);
        write_register(REG_BURST, 32'd0);
        write_register(REG_TIMEOUT, 32'd0);
        write_register(REG_MAXDELAY, 32'd0);
        write_register(REG_RESYNC, 32'hFFFF_FFFF);
        send_item(make_op(OP_START, 64'd0));
        it = make_op(OP_CONVERT, 64'd1); it.local_time = 64'h7FFF_FFFF_FFFF_FFFF;
        send_item(it);
        send_item(make_op(OP_FINISH, 64'd2));
        quiet_stretch = 0;
        random_phase(60);
        drain();

        // wall mode, burst of fifteen, widest limits
        write_register(REG_MODE, 32'd1);
        write_register(REG_BURST, 32'd15);
        write_register(REG_TIMEOUT, 32'hFFFF_FFFF);
        write_register(REG_MAXDELAY, 32'hFFFF_FFFF);
        write_register(REG_RESYNC, 32'd1);
        random_phase(250);
        drain();

        // back-pressure: receiver holds off while sender keeps offering
        write_register(REG_BURST, 32'd1);
        write_register(REG_TIMEOUT, 32'd30000);
        write_register(REG_MAXDELAY, 32'd20000);
        write_register(REG_RESYNC, 32'd50000);
        fork
            begin
                hold_receiver = 1;
                repeat (300) @(negedge aclk);
                hold_receiver = 0;
            end
            random_phase(150);
        join
        drain();

        // default-like settings, long stretch without idling then random again
        write_register(REG_BURST, 32'd4);
        write_register(REG_TIMEOUT, 32'd100000);
        write_register(REG_MAXDELAY, 32'd50000);
        write_register(REG_RESYNC, 32'd1000000);
        quiet_stretch = 1;
        random_phase(200);
        quiet_stretch = 0;
        random_phase(300);

        drain();
        if (board.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

`default_nettype wire

[sim.f]
hdl/hcos_pkg.sv
hdl/hcos_front.sv
hdl/hcos_queue.sv
hdl/hcos_engine.sv
hdl/host_clock_offset_sync_engine.sv
sim/host_clock_offset_sync_engine_tb.sv
